// ===== src/frsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed record stream validator package
// Types, codes and reset values shared by the validator files.
// ----------------------------------------------------------------------------
package frsv_pkg;

   localparam int NUM_FIELDS_DEFAULT = 5;

   localparam logic [31:0] MAGIC_RESET       = 32'h464F_5131;
   localparam logic [15:0] VERSION_RESET     = 16'd1;
   localparam logic [15:0] MAX_FIELD_RESET   = 16'd4096;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'(32 * 1024);
   localparam logic [16:0] MIN_PAYLOAD       = 17'd6;
   localparam logic [16:0] COUNT_MAX         = 17'h1_FFFF;

   typedef enum logic [1:0] {
      CSR_MAGIC_WORD        = 2'd0,
      CSR_EXPECTED_VERSION  = 2'd1,
      CSR_MAX_FIELD_BYTES   = 2'd2,
      CSR_MAX_PAYLOAD_BYTES = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SIZE     = 3'd1,
      ST_HEADER   = 3'd2,
      ST_QUANTITY = 3'd3,
      ST_CONTENT  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_MAGIC = 3'd0,
      PH_VER   = 3'd1,
      PH_FLEN  = 3'd2,
      PH_FDATA = 3'd3,
      PH_QTY   = 3'd4,
      PH_TRAIL = 3'd5,
      PH_DEAD  = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  content_byte;
      logic        content_valid;
      logic [2:0]  field_number;
      logic        message_done;
      logic [2:0]  status;
      logic [15:0] version_out;
      logic [31:0] quantity_out;
   } rsp_type;

endpackage

// ===== src/framed_record_stream_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed record stream validator
// Parses a framed payload one byte at a time, passes field content through
// and reports a status on the final byte.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while the result side does not stall,
// and each byte produces exactly one result. A byte is held in the input
// register, and the parse step between that register and the result
// register updates the parse state as it moves the byte's result into the
// result register, from which it is presented on the result port.
// The result register frees itself in the cycle it is taken, so
// back-pressure on the result side stalls the input only when both stages
// are full. Registers may be written only while no transaction is in flight.
module framed_record_stream_validator #(
   parameter int NUM_FIELDS = frsv_pkg::NUM_FIELDS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  frsv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output frsv_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import frsv_pkg::*;

   localparam logic [3:0] FIELD_LIMIT = 4'(NUM_FIELDS);

   logic        in_valid_ff;
   logic        in_valid_in;
   req_type     in_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic [31:0] magic_ff;
   logic [15:0] version_cfg_ff;
   logic [15:0] max_field_ff;
   logic [15:0] max_payload_ff;

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [2:0]  field_ff, field_in;
   logic [15:0] left_ff, left_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [15:0] held_version_ff, held_version_in;
   logic [16:0] total_ff, total_in;
   status_type  error_ff, error_in;
   logic        empty_ff, empty_in;

   logic        rsp_free;
   logic        req_fire;
   logic        stage_fire;
   logic [31:0] shift_next;
   logic        field_last;
   logic [15:0] left_dec;
   phase_type   field_end_phase;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || rsp_free;
   assign req_fire   = req_valid && req_ready;
   assign stage_fire = in_valid_ff && rsp_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign in_valid_in  = req_fire ? 1'b1 : (stage_fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = stage_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign shift_next      = {assembly_ff[23:0], in_ff.data_byte};
   assign field_last      = ({1'b0, field_ff} + 4'd1) >= FIELD_LIMIT;
   assign field_end_phase = field_last ? PH_QTY : PH_FLEN;
   assign left_dec        = (left_ff != 16'd0) ? left_ff - 16'd1 : left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         magic_ff        <= MAGIC_RESET;
         version_cfg_ff  <= VERSION_RESET;
         max_field_ff    <= MAX_FIELD_RESET;
         max_payload_ff  <= MAX_PAYLOAD_RESET;
         phase_ff        <= PH_MAGIC;
         count_ff        <= '0;
         field_ff        <= '0;
         left_ff         <= '0;
         assembly_ff     <= '0;
         held_version_ff <= '0;
         total_ff        <= '0;
         error_ff        <= ST_OK;
         empty_ff        <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         field_ff        <= field_in;
         left_ff         <= left_in;
         assembly_ff     <= assembly_in;
         held_version_ff <= held_version_in;
         total_ff        <= total_in;
         error_ff        <= error_in;
         empty_ff        <= empty_in;
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAGIC_WORD:        magic_ff       <= csr_wdata;
               CSR_EXPECTED_VERSION:  version_cfg_ff <= csr_wdata[15:0];
               CSR_MAX_FIELD_BYTES:   max_field_ff   <= csr_wdata[15:0];
               CSR_MAX_PAYLOAD_BYTES: max_payload_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_data;
      end
      if (stage_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      field_in        = field_ff;
      left_in         = left_ff;
      assembly_in     = assembly_ff;
      held_version_in = held_version_ff;
      total_in        = total_ff;
      error_in        = error_ff;
      empty_in        = empty_ff;
      rsp_in          = '0;
      if (stage_fire) begin
         if (total_ff != COUNT_MAX) begin
            total_in = total_ff + 17'd1;
         end
         case (phase_ff)
            PH_MAGIC: begin
               assembly_in = shift_next;
               if (count_ff == 2'd3) begin
                  count_in = 2'd0;
                  if (shift_next != magic_ff) begin
                     error_in = ST_HEADER;
                     phase_in = PH_DEAD;
                  end else begin
                     assembly_in = '0;
                     phase_in    = PH_VER;
                  end
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
            PH_VER: begin
               assembly_in = shift_next;
               if (count_ff != 2'd0) begin
                  count_in        = 2'd0;
                  held_version_in = shift_next[15:0];
                  assembly_in     = '0;
                  phase_in        = PH_FLEN;
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
            PH_FLEN: begin
               assembly_in = shift_next;
               if (count_ff == 2'd3) begin
                  count_in    = 2'd0;
                  assembly_in = '0;
                  if (shift_next > {16'd0, max_field_ff}) begin
                     error_in = ST_HEADER;
                     phase_in = PH_DEAD;
                  end else if (shift_next == 32'd0) begin
                     empty_in = 1'b1;
                     phase_in = field_end_phase;
                     if (!field_last) begin
                        field_in = field_ff + 3'd1;
                     end
                  end else begin
                     left_in  = shift_next[15:0];
                     phase_in = PH_FDATA;
                  end
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
            PH_FDATA: begin
               rsp_in.content_byte  = in_ff.data_byte;
               rsp_in.content_valid = 1'b1;
               rsp_in.field_number  = field_ff;
               left_in              = left_dec;
               if (left_dec == 16'd0) begin
                  phase_in = field_end_phase;
                  if (!field_last) begin
                     field_in = field_ff + 3'd1;
                  end
               end
            end
            PH_QTY: begin
               assembly_in = shift_next;
               if (count_ff == 2'd3) begin
                  count_in = 2'd0;
                  phase_in = PH_TRAIL;
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
            PH_TRAIL: begin
               if (error_ff == ST_OK) begin
                  error_in = ST_QUANTITY;
               end
            end
            default: ;
         endcase

         if (in_ff.last_byte) begin
            rsp_in.message_done = 1'b1;
            rsp_in.version_out  = held_version_in;
            if (phase_in == PH_TRAIL) begin
               rsp_in.quantity_out = assembly_in;
            end
            if (total_in < MIN_PAYLOAD || total_in > {1'b0, max_payload_ff}) begin
               rsp_in.status = ST_SIZE;
            end else if (error_in != ST_OK) begin
               rsp_in.status = error_in;
            end else if (phase_in == PH_QTY) begin
               rsp_in.status = ST_QUANTITY;
            end else if (phase_in != PH_TRAIL) begin
               rsp_in.status = ST_HEADER;
            end else if (held_version_in != version_cfg_ff || empty_in ||
                         assembly_in == 32'd0 || assembly_in[31]) begin
               rsp_in.status = ST_CONTENT;
            end else begin
               rsp_in.status = ST_OK;
            end
            phase_in        = PH_MAGIC;
            count_in        = '0;
            field_in        = '0;
            left_in         = '0;
            assembly_in     = '0;
            held_version_in = '0;
            total_in        = '0;
            error_in        = ST_OK;
            empty_in        = 1'b0;
         end
      end
   end

   // A final byte always leaves the parser ready for a fresh payload.
   assert property (@(posedge clock) disable iff (reset)
      (stage_fire && in_ff.last_byte) |=> (phase_ff == PH_MAGIC && total_ff == 17'd0))
      else $error("parse state not cleared after final byte");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.message_done) |->
      (rsp_ff.status == ST_OK && rsp_ff.version_out == 16'd0 && rsp_ff.quantity_out == 32'd0))
      else $error("summary fields set on a result that is not final");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.content_valid) |->
      (rsp_ff.content_byte == 8'd0 && rsp_ff.field_number == 3'd0))
      else $error("content fields set without content");

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, field_ff} < FIELD_LIMIT))
      else $error("field number beyond the configured field count");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FDATA) |-> (left_ff != 16'd0))
      else $error("content phase entered with no bytes left");

endmodule
